>>> hdl/ppcd_pkg.sv
package ppcd_pkg;

  localparam int unsigned KindWidth = 8;
  localparam int unsigned OeOffset  = 512;

  typedef logic [KindWidth-1:0] kind_t;

  // Primary opcodes that carry an extended opcode.
  localparam logic [5:0] OpPaired = 6'd4;
  localparam logic [5:0] OpBranch = 6'd19;
  localparam logic [5:0] OpInt    = 6'd31;
  localparam logic [5:0] OpFps    = 6'd59;
  localparam logic [5:0] OpFpd    = 6'd63;

  typedef struct packed {
    kind_t kind;
    logic  ovf;
  } dec_result_t;

  // Kind for primary opcodes without an extended opcode.
  function automatic kind_t primary_kind(input logic [5:0] op);
    kind_t k;
    begin
      k = '0;
      case (op)
        6'd3: k = 8'd1;   6'd7: k = 8'd2;   6'd8: k = 8'd3;   6'd10: k = 8'd4;
        6'd11: k = 8'd5;  6'd12: k = 8'd6;  6'd13: k = 8'd7;  6'd14: k = 8'd8;
        6'd15: k = 8'd9;  6'd16: k = 8'd10; 6'd17: k = 8'd11; 6'd18: k = 8'd12;
        6'd20: k = 8'd13; 6'd21: k = 8'd14; 6'd23: k = 8'd15; 6'd24: k = 8'd16;
        6'd25: k = 8'd17; 6'd26: k = 8'd18; 6'd27: k = 8'd19; 6'd28: k = 8'd20;
        6'd29: k = 8'd21; 6'd32: k = 8'd22; 6'd33: k = 8'd23; 6'd34: k = 8'd24;
        6'd35: k = 8'd25; 6'd36: k = 8'd26; 6'd37: k = 8'd27; 6'd38: k = 8'd28;
        6'd39: k = 8'd29; 6'd40: k = 8'd30; 6'd41: k = 8'd31; 6'd42: k = 8'd32;
        6'd43: k = 8'd33; 6'd44: k = 8'd34; 6'd45: k = 8'd35; 6'd46: k = 8'd36;
        6'd47: k = 8'd37; 6'd48: k = 8'd38; 6'd49: k = 8'd39; 6'd50: k = 8'd40;
        6'd51: k = 8'd41; 6'd52: k = 8'd42; 6'd53: k = 8'd43; 6'd54: k = 8'd44;
        6'd55: k = 8'd45; 6'd56: k = 8'd46; 6'd57: k = 8'd47; 6'd60: k = 8'd48;
        6'd61: k = 8'd49;
        default: k = '0;
      endcase
      return k;
    end
  endfunction

  function automatic kind_t op4_aform(input logic [4:0] x);
    kind_t k;
    begin
      k = '0;
      case (x)
        5'd10: k = 8'd50; 5'd11: k = 8'd51; 5'd12: k = 8'd52; 5'd13: k = 8'd53;
        5'd14: k = 8'd54; 5'd15: k = 8'd55; 5'd18: k = 8'd56; 5'd20: k = 8'd57;
        5'd21: k = 8'd58; 5'd23: k = 8'd59; 5'd24: k = 8'd60; 5'd25: k = 8'd61;
        5'd26: k = 8'd62; 5'd28: k = 8'd63; 5'd29: k = 8'd64; 5'd30: k = 8'd65;
        5'd31: k = 8'd66;
        default: k = '0;
      endcase
      return k;
    end
  endfunction

  function automatic kind_t op4_exact(input logic [9:0] x);
    kind_t k;
    begin
      k = '0;
      case (x)
        10'd0: k = 8'd67;   10'd32: k = 8'd68;  10'd64: k = 8'd69;  10'd96: k = 8'd70;
        10'd6: k = 8'd71;   10'd7: k = 8'd72;   10'd38: k = 8'd73;  10'd39: k = 8'd74;
        10'd40: k = 8'd75;  10'd72: k = 8'd76;  10'd136: k = 8'd77; 10'd264: k = 8'd78;
        10'd528: k = 8'd79; 10'd560: k = 8'd80; 10'd592: k = 8'd81; 10'd624: k = 8'd82;
        10'd1014: k = 8'd83;
        default: k = '0;
      endcase
      return k;
    end
  endfunction

  function automatic kind_t op19_exact(input logic [9:0] x);
    kind_t k;
    begin
      k = '0;
      case (x)
        10'd0: k = 8'd84;   10'd16: k = 8'd85;  10'd33: k = 8'd86;  10'd50: k = 8'd87;
        10'd129: k = 8'd88; 10'd150: k = 8'd89; 10'd193: k = 8'd90; 10'd225: k = 8'd91;
        10'd257: k = 8'd92; 10'd289: k = 8'd93; 10'd417: k = 8'd94; 10'd449: k = 8'd95;
        10'd528: k = 8'd96;
        default: k = '0;
      endcase
      return k;
    end
  endfunction

  function automatic kind_t op31_exact(input logic [9:0] x);
    kind_t k;
    begin
      k = '0;
      case (x)
        10'd0: k = 8'd97;    10'd4: k = 8'd98;    10'd8: k = 8'd99;    10'd10: k = 8'd100;
        10'd11: k = 8'd101;  10'd19: k = 8'd102;  10'd20: k = 8'd103;  10'd23: k = 8'd104;
        10'd24: k = 8'd105;  10'd26: k = 8'd106;  10'd28: k = 8'd107;  10'd32: k = 8'd108;
        10'd40: k = 8'd109;  10'd54: k = 8'd110;  10'd55: k = 8'd111;  10'd60: k = 8'd112;
        10'd75: k = 8'd113;  10'd83: k = 8'd114;  10'd86: k = 8'd110;  10'd87: k = 8'd115;
        10'd104: k = 8'd116; 10'd119: k = 8'd117; 10'd124: k = 8'd118; 10'd136: k = 8'd119;
        10'd138: k = 8'd120; 10'd144: k = 8'd121; 10'd146: k = 8'd122; 10'd150: k = 8'd123;
        10'd151: k = 8'd124; 10'd183: k = 8'd125; 10'd200: k = 8'd126; 10'd202: k = 8'd127;
        10'd210: k = 8'd128; 10'd215: k = 8'd129; 10'd232: k = 8'd130; 10'd234: k = 8'd131;
        10'd235: k = 8'd132; 10'd242: k = 8'd133; 10'd246: k = 8'd110; 10'd247: k = 8'd134;
        10'd266: k = 8'd135; 10'd278: k = 8'd110; 10'd279: k = 8'd136; 10'd284: k = 8'd137;
        10'd306: k = 8'd138; 10'd311: k = 8'd139; 10'd316: k = 8'd140; 10'd339: k = 8'd141;
        10'd343: k = 8'd142; 10'd371: k = 8'd143; 10'd375: k = 8'd144; 10'd407: k = 8'd145;
        10'd412: k = 8'd146; 10'd439: k = 8'd147; 10'd444: k = 8'd148; 10'd459: k = 8'd149;
        10'd467: k = 8'd150; 10'd470: k = 8'd110; 10'd476: k = 8'd151; 10'd491: k = 8'd152;
        10'd512: k = 8'd153; 10'd534: k = 8'd154; 10'd535: k = 8'd155; 10'd536: k = 8'd156;
        10'd567: k = 8'd157; 10'd595: k = 8'd158; 10'd598: k = 8'd159; 10'd599: k = 8'd160;
        10'd631: k = 8'd161; 10'd659: k = 8'd162; 10'd662: k = 8'd163; 10'd663: k = 8'd164;
        10'd695: k = 8'd165; 10'd727: k = 8'd166; 10'd759: k = 8'd167; 10'd790: k = 8'd168;
        10'd792: k = 8'd169; 10'd824: k = 8'd170; 10'd854: k = 8'd159; 10'd918: k = 8'd171;
        10'd922: k = 8'd172; 10'd954: k = 8'd173; 10'd982: k = 8'd110; 10'd983: k = 8'd174;
        10'd1014: k = 8'd83; 10'd566: k = 8'd175;
        default: k = '0;
      endcase
      return k;
    end
  endfunction

  // True for the XO-form arithmetic that has an OE alias at base plus 512.
  function automatic logic oe_base(input logic [8:0] x);
    logic b;
    begin
      b = 1'b0;
      case (x)
        9'd8, 9'd10, 9'd40, 9'd104, 9'd136, 9'd138, 9'd200, 9'd202, 9'd232,
        9'd234, 9'd235, 9'd266, 9'd459, 9'd491: b = 1'b1;
        default: b = 1'b0;
      endcase
      return b;
    end
  endfunction

  function automatic kind_t op59_kind(input logic [4:0] x);
    kind_t k;
    begin
      k = '0;
      case (x)
        5'd18: k = 8'd176; 5'd20: k = 8'd177; 5'd21: k = 8'd178; 5'd24: k = 8'd179;
        5'd25: k = 8'd180; 5'd28: k = 8'd181; 5'd29: k = 8'd182; 5'd30: k = 8'd183;
        5'd31: k = 8'd184;
        default: k = '0;
      endcase
      return k;
    end
  endfunction

  function automatic kind_t op63_aform(input logic [4:0] x);
    kind_t k;
    begin
      k = '0;
      case (x)
        5'd18: k = 8'd185; 5'd20: k = 8'd186; 5'd21: k = 8'd187; 5'd23: k = 8'd188;
        5'd25: k = 8'd189; 5'd26: k = 8'd190; 5'd28: k = 8'd191; 5'd29: k = 8'd192;
        5'd30: k = 8'd193; 5'd31: k = 8'd194;
        default: k = '0;
      endcase
      return k;
    end
  endfunction

  function automatic kind_t op63_exact(input logic [9:0] x);
    kind_t k;
    begin
      k = '0;
      case (x)
        10'd0: k = 8'd195;   10'd12: k = 8'd196;  10'd14: k = 8'd197;  10'd15: k = 8'd198;
        10'd32: k = 8'd199;  10'd38: k = 8'd200;  10'd40: k = 8'd201;  10'd64: k = 8'd202;
        10'd70: k = 8'd203;  10'd72: k = 8'd204;  10'd134: k = 8'd205; 10'd136: k = 8'd206;
        10'd264: k = 8'd207; 10'd583: k = 8'd208; 10'd711: k = 8'd209;
        default: k = '0;
      endcase
      return k;
    end
  endfunction

endpackage

>>> hdl/ppcd_if.sv
interface ppcd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;
  modport source (output valid, output instr_word, input ready);
  modport sink (input valid, input instr_word, output ready);
endinterface

interface ppcd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] instr_kind;
  logic       is_illegal;
  logic       overflow_form;
  modport source (output valid, output instr_kind, output is_illegal,
                  output overflow_form, input ready);
  modport sink (input valid, input instr_kind, input is_illegal,
                input overflow_form, output ready);
endinterface

>>> hdl/ppc_instruction_class_decoder_core.sv
// Instruction class decoder.
// Input channel in_ch carries one 32-bit instruction word per handshake.
// Output channel out_ch carries the instruction kind (0 when illegal), an
// illegal flag and a flag for the opcode 31 overflow-enable alias.
// An accepted word is registered in the input register, decoded by table
// logic, and its result is registered in the result register, where it is
// held under a stall until out_ch takes it.
// Throughput is one word per cycle unless out_ch stalls; the two register
// stages each advance whenever the stage after them is empty or being emptied.
// A stall on out_ch holds both stages; in_ch ready drops only when both are full.
// Reset empties both stages; there is no other state.
module ppc_instruction_class_decoder_core
  import ppcd_pkg::*;
(
  input logic             clk,
  input logic             rst,
  ppcd_in_if.sink         in_ch,
  ppcd_out_if.source      out_ch
);

  logic        in_valid;
  logic [31:0] in_word;
  logic        res_valid;
  dec_result_t res;
  dec_result_t dec;
  logic        res_load;
  logic        in_load;

  // Result stage loads when empty or when its word is taken.
  assign res_load = !res_valid || out_ch.ready;
  assign in_load  = !in_valid || res_load;
  assign in_ch.ready = in_load;

  ppcd_decode u_decode (
    .word   (in_word),
    .result (dec)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_load) begin
      in_valid <= in_ch.valid;
    end
    if (in_load && in_ch.valid) begin
      in_word <= in_ch.instr_word;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= in_valid;
    end
    if (res_load && in_valid) begin
      res <= dec;
    end
  end

  assign out_ch.valid         = res_valid;
  assign out_ch.instr_kind    = res.kind;
  assign out_ch.is_illegal    = (res.kind == '0);
  assign out_ch.overflow_form = res.ovf;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !out_ch.ready |=> res_valid && $stable(res))
    else $error("result changed under stall");
  a_ovf_op31: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.ovf |-> res.kind != '0)
    else $error("overflow alias without kind");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> in_valid && res_valid)
    else $error("input stalled with free stage");

endmodule

>>> hdl/ppcd_decode.sv
module ppcd_decode
  import ppcd_pkg::*;
(
  input  logic [31:0]  word,
  output dec_result_t  result
);

  logic [5:0] opcd;
  logic [9:0] xo10;
  logic [4:0] xo5;
  kind_t      exact4;
  kind_t      exact31;
  kind_t      exact63;
  kind_t      alias31;
  logic       alias_hit;

  assign opcd = word[31:26];
  assign xo10 = word[10:1];
  assign xo5  = word[5:1];

  assign exact4  = op4_exact(xo10);
  assign exact31 = op31_exact(xo10);
  assign exact63 = op63_exact(xo10);

  // OE alias: upper half of the extended space, base taken from the low nine bits.
  assign alias_hit = xo10[9] && oe_base(xo10[8:0]);
  assign alias31   = op31_exact({1'b0, xo10[8:0]});

  // Select by primary opcode; exact entries win over A-form entries.
  always_comb begin
    result = '0;
    unique case (opcd)
      OpPaired: result.kind = (exact4 != '0) ? exact4 : op4_aform(xo5);
      OpBranch: result.kind = op19_exact(xo10);
      OpInt: begin
        if (exact31 != '0) begin
          result.kind = exact31;
        end else if (alias_hit) begin
          result.kind = alias31;
          result.ovf  = 1'b1;
        end
      end
      OpFps: result.kind = op59_kind(xo5);
      OpFpd: result.kind = (exact63 != '0) ? exact63 : op63_aform(xo5);
      default: result.kind = primary_kind(opcd);
    endcase
  end

endmodule
